// File: rtl/ntoe_pkg.sv
// Shared types and constants for the node table with oldest-entry eviction.
// No dependencies.
package ntoe_pkg;

    localparam int TableEntriesDefault = 32;
    localparam logic [7:0] LocMaskReset = 8'h10;
    localparam logic [3:0] TypeMask = 4'hF;
    localparam logic [7:0] LocMinLen = 8'd9;

    typedef enum logic [1:0] {
        KIND_NEW   = 2'd0,
        KIND_KNOWN = 2'd1,
        KIND_ENTRY = 2'd2,
        KIND_END   = 2'd3
    } t_kind;

    typedef struct packed {
        logic        action;
        logic [63:0] key_word0;
        logic [63:0] key_word1;
        logic [63:0] key_word2;
        logic [63:0] key_word3;
        logic [7:0]  advert_flags;
        logic [7:0]  advert_length;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [31:0] now_time;
        logic [31:0] since_time;
        logic        app_paired;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  slot_index;
        logic [63:0] out_key_word0;
        logic [63:0] out_key_word1;
        logic [63:0] out_key_word2;
        logic [63:0] out_key_word3;
        logic [3:0]  node_type;
        logic signed [31:0] out_latitude;
        logic signed [31:0] out_longitude;
        logic [31:0] modified_time;
        logic        last_of_run;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the item
        logic scan_rd;   // read slot at scan pointer
        logic scan_eval; // evaluate the slot read last cycle
        logic scan_rst;  // reset scan pointer
        logic write;     // update chosen slot
        logic emit_adv;  // emit advert notice
        logic emit_end;  // emit list end
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic action;
        logic scan_last; // pointer at last occupied slot
        logic empty;
        logic paired;
    } t_stat;

endpackage

// File: rtl/ntoe_datapath.sv
// Datapath: slot stores, scan pointer, match/oldest search, result register.
// Depends on ntoe_pkg.
module ntoe_datapath #(
    parameter int TABLE_ENTRIES = ntoe_pkg::TableEntriesDefault,
    localparam int AW = $clog2(TABLE_ENTRIES),
    localparam int CW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ntoe_pkg::t_cmd      i_cmd,
    output ntoe_pkg::t_stat     o_stat,
    input  ntoe_pkg::t_in_item  i_item,
    input  logic [7:0]          i_loc_mask,
    output ntoe_pkg::t_out_item o_result,
    output logic                o_result_valid
);
    logic [255:0]       key_mem [TABLE_ENTRIES];
    logic [3:0]         type_mem [TABLE_ENTRIES];
    logic [31:0]        lat_mem [TABLE_ENTRIES];
    logic [31:0]        lon_mem [TABLE_ENTRIES];
    logic [31:0]        mod_mem [TABLE_ENTRIES];

    ntoe_pkg::t_in_item r_item;
    logic [CW-1:0]      r_count;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_rd_idx;
    logic [255:0]       r_rd_key;
    logic [3:0]         r_rd_type;
    logic [31:0]        r_rd_lat;
    logic [31:0]        r_rd_lon;
    logic [31:0]        r_rd_mod;
    logic               r_found;
    logic [AW-1:0]      r_idx;
    logic [AW-1:0]      r_old_idx;
    logic [31:0]        r_old_mod;
    logic [31:0]        r_newest;
    logic               r_fresh;
    ntoe_pkg::t_out_item r_res;
    logic               r_res_v;
    ntoe_pkg::t_out_item n_res;
    logic               n_res_v;

    logic [7:0]   flags;
    logic         loc_ok;
    logic         full;
    logic [AW-1:0] w_idx;
    logic [255:0] in_key;
    logic [4:0]   rd_slot5;

    assign in_key = {r_item.key_word3, r_item.key_word2, r_item.key_word1,
                     r_item.key_word0};
    assign flags  = (r_item.advert_length != 8'd0) ? r_item.advert_flags : 8'd0;
    assign loc_ok = ((flags & i_loc_mask) != 8'd0) &&
                    (r_item.advert_length >= ntoe_pkg::LocMinLen);
    assign full   = (r_count >= CW'(TABLE_ENTRIES));
    assign w_idx  = r_found ? r_idx : (full ? r_old_idx : r_count[AW-1:0]);
    assign rd_slot5 = 5'(r_rd_idx);

    assign o_stat.action    = r_item.action;
    assign o_stat.scan_last = ((CW+1)'(r_ptr) == (CW+1)'(r_count) - (CW+1)'(1));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.paired    = r_item.app_paired;

    // next result beat; a fresh slot's stored fields follow from the held item
    always_comb begin
        n_res   = '0;
        n_res_v = 1'b0;
        if (i_cmd.scan_eval && r_item.action) begin
            n_res.kind          = ntoe_pkg::KIND_ENTRY;
            n_res.slot_index    = rd_slot5;
            {n_res.out_key_word3, n_res.out_key_word2, n_res.out_key_word1,
             n_res.out_key_word0} = r_rd_key;
            n_res.node_type     = r_rd_type;
            n_res.out_latitude  = r_rd_lat;
            n_res.out_longitude = r_rd_lon;
            n_res.modified_time = r_rd_mod;
            n_res_v             = (r_rd_mod > r_item.since_time);
        end else if (i_cmd.emit_end) begin
            n_res.kind          = ntoe_pkg::KIND_END;
            n_res.modified_time = r_newest;
            n_res.last_of_run   = 1'b1;
            n_res_v             = 1'b1;
        end else if (i_cmd.emit_adv) begin
            n_res.slot_index = 5'(r_idx);
            {n_res.out_key_word3, n_res.out_key_word2, n_res.out_key_word1,
             n_res.out_key_word0} = in_key;
            n_res.last_of_run = 1'b1;
            n_res_v           = 1'b1;
            if (r_fresh) begin
                n_res.kind          = ntoe_pkg::KIND_NEW;
                n_res.node_type     = flags[3:0] & ntoe_pkg::TypeMask;
                n_res.out_latitude  = loc_ok ? r_item.latitude : '0;
                n_res.out_longitude = loc_ok ? r_item.longitude : '0;
                n_res.modified_time = r_item.now_time;
            end else begin
                n_res.kind = ntoe_pkg::KIND_KNOWN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        // storage, no reset
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.scan_rd) begin
            r_rd_key  <= key_mem[r_ptr];
            r_rd_type <= type_mem[r_ptr];
            r_rd_lat  <= lat_mem[r_ptr];
            r_rd_lon  <= lon_mem[r_ptr];
            r_rd_mod  <= mod_mem[r_ptr];
            r_rd_idx  <= r_ptr;
        end
        if (i_cmd.write) begin
            key_mem[w_idx]  <= in_key;
            type_mem[w_idx] <= flags[3:0] & ntoe_pkg::TypeMask;
            if (loc_ok) begin
                lat_mem[w_idx] <= r_item.latitude;
                lon_mem[w_idx] <= r_item.longitude;
            end else if (!r_found) begin
                lat_mem[w_idx] <= '0;
                lon_mem[w_idx] <= '0;
            end
            mod_mem[w_idx] <= r_item.now_time;
            r_fresh <= !r_found;
            r_idx   <= w_idx;
        end
        if (i_cmd.scan_eval && !r_item.action) begin
            if (!r_found && r_rd_key == in_key) begin
                r_found <= 1'b1;
                r_idx   <= r_rd_idx;
            end
            if (r_rd_idx == '0 || r_rd_mod < r_old_mod) begin
                r_old_idx <= r_rd_idx;
                r_old_mod <= r_rd_mod;
            end
        end
        if (i_cmd.load) r_found <= 1'b0;
        if (i_cmd.scan_eval && r_item.action && r_rd_mod > r_item.since_time
                && r_rd_mod > r_newest)
            r_newest <= r_rd_mod;
        if (i_cmd.load) r_newest <= '0;

        // result payload
        r_res <= n_res;

        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_res_v <= 1'b0;
        end else begin
            r_res_v <= n_res_v;
            if (i_cmd.scan_rst)      r_ptr <= '0;
            else if (i_cmd.scan_rd)  r_ptr <= r_ptr + AW'(1);
            if (i_cmd.write && !r_found && !full) r_count <= r_count + CW'(1);
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_v;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
    a_grow_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_count != $past(r_count) |-> r_count == $past(r_count) + CW'(1))
        else $error("entry count jumped");
    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> int'(w_idx) < TABLE_ENTRIES)
        else $error("write slot out of range");
endmodule

// File: rtl/ntoe_ctrl.sv
// Controller state machine sequencing scan, update and result beats.
// Depends on ntoe_pkg.
module ntoe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    output logic            o_busy,
    output ntoe_pkg::t_cmd  o_cmd,
    input  ntoe_pkg::t_stat i_stat
);
    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_EVAL, S_WRITE, S_NOTE, S_END
    } t_state;

    t_state r_state;
    logic   r_last;

    always_comb begin
        o_cmd = '0;
        o_cmd.load     = (r_state == S_IDLE) && i_start;
        o_cmd.scan_rst = (r_state == S_IDLE);
        o_cmd.scan_rd  = (r_state == S_READ);
        o_cmd.scan_eval = (r_state == S_EVAL);
        o_cmd.write    = (r_state == S_WRITE);
        o_cmd.emit_adv = (r_state == S_NOTE);
        o_cmd.emit_end = (r_state == S_END);
    end
    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) r_state <= S_READ;
                S_READ: begin
                    if (i_stat.empty) begin
                        r_state <= i_stat.action ? S_END : S_WRITE;
                    end else begin
                        r_last  <= i_stat.scan_last;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (!r_last) r_state <= S_READ;
                    else r_state <= i_stat.action ? S_END : S_WRITE;
                end
                S_WRITE: r_state <= i_stat.paired ? S_NOTE : S_IDLE;
                S_NOTE:  r_state <= S_IDLE;
                S_END:   r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.scan_rd, o_cmd.scan_eval, o_cmd.write, o_cmd.emit_adv,
                  o_cmd.emit_end})) else $error("overlapping commands");
    a_eval_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_eval |-> $past(o_cmd.scan_rd)) else $error("eval without read");
    a_note_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_adv |-> $past(o_cmd.write)) else $error("notice without update");
endmodule

// File: rtl/node_table_oldest_evict_unit.sv
// Top level of the node table with oldest-entry eviction.
// Depends on ntoe_pkg, ntoe_ctrl, ntoe_datapath.
//
// An item is taken when start is high and busy is low. The table is walked
// slot by slot; each occupied slot is read and then compared in turn.
// An advert then writes its slot and, when paired, gives one notice beat; a
// list gives one beat per newer entry and an end beat. Every result is shown
// for one cycle with o_result_valid and cannot be held off. Config writes to
// the location flag mask are taken while the unit is idle (ready = !busy).
module node_table_oldest_evict_unit #(
    parameter int TABLE_ENTRIES = ntoe_pkg::TableEntriesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ntoe_pkg::t_in_item  i_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [7:0]          i_cfg_data,
    output ntoe_pkg::t_out_item o_result,
    output logic                o_result_valid
);
    ntoe_pkg::t_cmd  cmd;
    ntoe_pkg::t_stat stat;
    logic [7:0]      r_loc_mask;

    assign o_cfg_ready = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_loc_mask <= ntoe_pkg::LocMaskReset;
        else if (i_cfg_valid && o_cfg_ready) r_loc_mask <= i_cfg_data;
    end

    ntoe_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .o_busy(busy),
        .o_cmd(cmd), .i_stat(stat)
    );

    ntoe_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_item,
        .i_loc_mask(r_loc_mask), .o_result, .o_result_valid
    );
endmodule
